### sv/rsdpxy_pkg.sv
// ----------------------------------------------------------------------------
// rsdpxy_pkg
// Shared types, constants and the sine table generator for the range scan
// deframer with polar to cartesian projection.
// ----------------------------------------------------------------------------
package rsdpxy_pkg;

    // default sizing
    localparam int unsigned MAX_SAMPLES_DEF    = 512;
    localparam int unsigned TRIG_FRAC_BITS_DEF = 15;

    // link framing
    localparam int unsigned SKIP_BYTES = 10;
    localparam int unsigned HEAD_BYTES = 7;
    localparam int unsigned TAIL_BYTES = 3;

    // angles in quarter degrees
    localparam int unsigned ANGLE_MAX  = 720;
    localparam int unsigned ANGLE_HALF = 360;
    localparam int unsigned TRIG_DEPTH = ANGLE_HALF + 1;
    localparam int unsigned TRIG_AW    = 9;

    // pi in Q30
    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    // taylor series divisors (2k)(2k+1) for k = 1..12, entry k-1
    localparam logic [11:0][9:0] TAYLOR_DIV = {
        10'd600, 10'd506, 10'd420, 10'd342, 10'd272, 10'd210,
        10'd156, 10'd110, 10'd72,  10'd42,  10'd20,  10'd6
    };

    // configuration port
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 10;

    localparam logic [CFG_INDEX_W-1:0] REG_CONTINUOUS_ON = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_COUNT  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ANGLE_STEP    = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ANGLE_OFFSET  = 2'd3;

    // register reset values
    localparam logic [9:0] SAMPLE_COUNT_RST = 10'd181;
    localparam logic [2:0] ANGLE_STEP_RST   = 3'd4;
    localparam logic [9:0] ANGLE_OFFSET_RST = 10'd0;

    // per-sample information carried down the pipeline
    typedef struct packed {
        logic [8:0]  sample_index;
        logic [15:0] range_value;
        logic        last_sample;
        logic        cos_neg;
    } sample_meta_t;

    // sin(a*pi/720) for 0 <= a <= 360, Q30 taylor series rounded to Q1.frac;
    // only evaluated on constants to build the lookup table
    function automatic logic [63:0] quarter_sin(input int unsigned a,
                                                input int unsigned frac);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        x    = (64'(a) * PI_Q30) / 64'(ANGLE_MAX);
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        for (int unsigned k = 1; k <= 12; k++)
        begin
            term = ((term * x2) >> 30) / 64'(TAYLOR_DIV[k - 1]);
            if (k[0])
            begin
                sum = (sum >= term) ? (sum - term) : 64'd0;
            end
            else
            begin
                sum = sum + term;
            end
        end
        return (sum + (64'd1 << (29 - frac))) >> (30 - frac);
    endfunction

endpackage

### sv/range_scan_deframe_polar_to_xy.sv
// A sample beat passes the stage 1, stage 2 and output registers in turn after the byte carrying its high half.
// Throughput: one byte per cycle while not stalled; the three-stage pipeline (framing, sine table
// read, multiply) stalls as a whole only while a held result beat is not taken.
// Reset: asynchronous, active low; registers take their listed reset values,
// continuous mode is off and the pipeline is empty.
// ----------------------------------------------------------------------------
// range_scan_deframe_polar_to_xy
// Laser range scan byte deframer with polar to cartesian projection of each
// range sample.
// ----------------------------------------------------------------------------
module range_scan_deframe_polar_to_xy #(
    parameter int unsigned MAX_SAMPLES    = rsdpxy_pkg::MAX_SAMPLES_DEF,
    parameter int unsigned TRIG_FRAC_BITS = rsdpxy_pkg::TRIG_FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [7:0]                         rx_byte,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [8:0]                         sample_index,
    output logic [15:0]                        range_value,
    output logic signed [16:0]                 x_coord,
    output logic [15:0]                        y_coord,
    output logic                               last_sample,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rsdpxy_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rsdpxy_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic                           advance;
    logic                           s1_valid;
    rsdpxy_pkg::sample_meta_t       s1_meta;
    logic [rsdpxy_pkg::TRIG_AW-1:0] sin_addr;
    logic [rsdpxy_pkg::TRIG_AW-1:0] cos_addr;
    logic [TRIG_FRAC_BITS:0]        sin_data;
    logic [TRIG_FRAC_BITS:0]        cos_data;

    // whole pipeline moves unless a result beat is held
    assign advance   = !out_valid || out_ready;
    assign in_ready  = advance;
    assign cfg_ready = 1'b1;

    rsdpxy_deframe #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_deframe (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .byte_accept (in_valid && in_ready),
        .rx_byte     (rx_byte),
        .cfg_accept  (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s1_valid    (s1_valid),
        .s1_meta     (s1_meta),
        .sin_addr    (sin_addr),
        .cos_addr    (cos_addr)
    );

    rsdpxy_trig_rom #(
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_trig_rom (
        .clk      (clk),
        .en       (advance),
        .sin_addr (sin_addr),
        .cos_addr (cos_addr),
        .sin_data (sin_data),
        .cos_data (cos_data)
    );

    rsdpxy_project #(
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_project (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (advance),
        .s1_valid     (s1_valid),
        .s1_meta      (s1_meta),
        .sin_data     (sin_data),
        .cos_data     (cos_data),
        .out_valid    (out_valid),
        .sample_index (sample_index),
        .range_value  (range_value),
        .x_coord      (x_coord),
        .y_coord      (y_coord),
        .last_sample  (last_sample)
    );

endmodule

### sv/rsdpxy_deframe.sv
// ----------------------------------------------------------------------------
// rsdpxy_deframe
// Configuration registers, start-up byte skip, packet framing and range
// assembly. Registers each completed sample with its trig table addresses.
// ----------------------------------------------------------------------------
module rsdpxy_deframe #(
    parameter int unsigned MAX_SAMPLES = rsdpxy_pkg::MAX_SAMPLES_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 advance,
    input  logic                                 byte_accept,
    input  logic [7:0]                           rx_byte,
    input  logic                                 cfg_accept,
    input  logic [rsdpxy_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [rsdpxy_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                                 s1_valid,
    output rsdpxy_pkg::sample_meta_t             s1_meta,
    output logic [rsdpxy_pkg::TRIG_AW-1:0]       sin_addr,
    output logic [rsdpxy_pkg::TRIG_AW-1:0]       cos_addr
);

    localparam int unsigned NW = $clog2(MAX_SAMPLES + 1);
    localparam int unsigned PW = $clog2(rsdpxy_pkg::HEAD_BYTES + 2 * MAX_SAMPLES
                                        + rsdpxy_pkg::TAIL_BYTES);
    localparam int unsigned JW = $clog2(MAX_SAMPLES);
    localparam int unsigned AW = (JW + 4 > 11) ? JW + 4 : 11;
    localparam int unsigned TRIG_AW_W = rsdpxy_pkg::TRIG_AW;

    // configuration registers
    logic       continuous_on_reg;
    logic [9:0] sample_count_reg;
    logic [2:0] angle_step_reg;
    logic [9:0] angle_offset_reg;

    // framing state
    logic [3:0]    skip_count_reg;
    logic [3:0]    skip_count_next;
    logic [PW-1:0] packet_pos_reg;
    logic [PW-1:0] packet_pos_next;
    logic [7:0]    low_byte_hold_reg;
    logic [7:0]    low_byte_hold_next;

    // stage 1 register
    logic                     s1_valid_reg;
    logic                     s1_valid_next;
    rsdpxy_pkg::sample_meta_t s1_meta_reg;
    rsdpxy_pkg::sample_meta_t s1_meta_next;
    logic [rsdpxy_pkg::TRIG_AW-1:0] sin_addr_reg;
    logic [rsdpxy_pkg::TRIG_AW-1:0] sin_addr_next;
    logic [rsdpxy_pkg::TRIG_AW-1:0] cos_addr_reg;
    logic [rsdpxy_pkg::TRIG_AW-1:0] cos_addr_next;

    logic [NW-1:0] n_eff;
    logic [PW-1:0] data_end;
    logic [PW-1:0] pkt_last;
    logic [PW-1:0] data_off;
    logic          in_data;
    logic          skipping;
    logic [JW-1:0] sample_j;
    logic [AW-1:0] angle_raw;
    logic [9:0]    angle;

    // effective sample count, clamped to 1..MAX_SAMPLES
    always_comb
    begin
        if (sample_count_reg == 10'd0)
        begin
            n_eff = NW'(1);
        end
        else if (11'(sample_count_reg) > 11'(MAX_SAMPLES))
        begin
            n_eff = NW'(MAX_SAMPLES);
        end
        else
        begin
            n_eff = NW'(sample_count_reg);
        end
    end

    // packet geometry and position decode
    assign data_end = PW'(rsdpxy_pkg::HEAD_BYTES) + (PW'(n_eff) << 1);
    assign pkt_last = data_end + PW'(rsdpxy_pkg::TAIL_BYTES - 1);
    assign data_off = packet_pos_reg - PW'(rsdpxy_pkg::HEAD_BYTES);
    assign in_data  = (packet_pos_reg >= PW'(rsdpxy_pkg::HEAD_BYTES))
                      && (packet_pos_reg < data_end);
    assign skipping = (skip_count_reg < 4'(rsdpxy_pkg::SKIP_BYTES));
    assign sample_j = JW'(data_off >> 1);

    // sample angle, clamped to 180 degrees
    assign angle_raw = AW'(sample_j) * AW'(angle_step_reg) + AW'(angle_offset_reg);
    assign angle     = (angle_raw > AW'(rsdpxy_pkg::ANGLE_MAX))
                       ? 10'(rsdpxy_pkg::ANGLE_MAX) : angle_raw[9:0];

    // next state for framing and the stage 1 register
    always_comb
    begin
        skip_count_next    = skip_count_reg;
        packet_pos_next    = packet_pos_reg;
        low_byte_hold_next = low_byte_hold_reg;
        s1_valid_next      = 1'b0;

        s1_meta_next.sample_index = 9'(sample_j);
        s1_meta_next.range_value  = {rx_byte, low_byte_hold_reg};
        s1_meta_next.last_sample  = (NW'(sample_j) == (n_eff - NW'(1)));
        s1_meta_next.cos_neg      = (angle > 10'(rsdpxy_pkg::ANGLE_HALF));

        if (angle > 10'(rsdpxy_pkg::ANGLE_HALF))
        begin
            sin_addr_next = TRIG_AW_W'(10'(rsdpxy_pkg::ANGLE_MAX) - angle);
            cos_addr_next = TRIG_AW_W'(angle - 10'(rsdpxy_pkg::ANGLE_HALF));
        end
        else
        begin
            sin_addr_next = TRIG_AW_W'(angle);
            cos_addr_next = TRIG_AW_W'(10'(rsdpxy_pkg::ANGLE_HALF) - angle);
        end

        if (byte_accept && continuous_on_reg)
        begin
            if (skipping)
            begin
                skip_count_next = skip_count_reg + 4'd1;
            end
            else
            begin
                if (in_data && !data_off[0])
                begin
                    low_byte_hold_next = rx_byte;
                end
                s1_valid_next   = in_data && data_off[0];
                packet_pos_next = (packet_pos_reg >= pkt_last)
                                  ? '0 : packet_pos_reg + PW'(1);
            end
        end

        // enabling continuous mode restarts the skip and the framing
        if (cfg_accept && (cfg_index == rsdpxy_pkg::REG_CONTINUOUS_ON) && cfg_data[0])
        begin
            skip_count_next = '0;
            packet_pos_next = '0;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            continuous_on_reg <= 1'b0;
            sample_count_reg  <= rsdpxy_pkg::SAMPLE_COUNT_RST;
            angle_step_reg    <= rsdpxy_pkg::ANGLE_STEP_RST;
            angle_offset_reg  <= rsdpxy_pkg::ANGLE_OFFSET_RST;
        end
        else if (cfg_accept)
        begin
            case (cfg_index)
                rsdpxy_pkg::REG_CONTINUOUS_ON: continuous_on_reg <= cfg_data[0];
                rsdpxy_pkg::REG_SAMPLE_COUNT:  sample_count_reg  <= cfg_data[9:0];
                rsdpxy_pkg::REG_ANGLE_STEP:    angle_step_reg    <= cfg_data[2:0];
                rsdpxy_pkg::REG_ANGLE_OFFSET:  angle_offset_reg  <= cfg_data[9:0];
                default:
                begin
                end
            endcase
        end
    end

    // framing state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_count_reg    <= '0;
            packet_pos_reg    <= '0;
            low_byte_hold_reg <= '0;
        end
        else
        begin
            skip_count_reg    <= skip_count_next;
            packet_pos_reg    <= packet_pos_next;
            low_byte_hold_reg <= low_byte_hold_next;
        end
    end

    // stage 1 valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // stage 1 payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_meta_reg  <= s1_meta_next;
            sin_addr_reg <= sin_addr_next;
            cos_addr_reg <= cos_addr_next;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_meta  = s1_meta_reg;
    assign sin_addr = sin_addr_reg;
    assign cos_addr = cos_addr_reg;

endmodule

### sv/rsdpxy_trig_rom.sv
// ----------------------------------------------------------------------------
// rsdpxy_trig_rom
// First quadrant sine table in Q1.F, two read ports with registered data.
// ----------------------------------------------------------------------------
module rsdpxy_trig_rom #(
    parameter int unsigned TRIG_FRAC_BITS = rsdpxy_pkg::TRIG_FRAC_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             en,
    input  logic [rsdpxy_pkg::TRIG_AW-1:0]   sin_addr,
    input  logic [rsdpxy_pkg::TRIG_AW-1:0]   cos_addr,
    output logic [TRIG_FRAC_BITS:0]          sin_data,
    output logic [TRIG_FRAC_BITS:0]          cos_data
);

    localparam int unsigned TW = TRIG_FRAC_BITS + 1;

    logic [TW-1:0] rom_w [0:rsdpxy_pkg::TRIG_DEPTH-1];
    logic [TW-1:0] sin_data_reg;
    logic [TW-1:0] cos_data_reg;

    // table contents, fixed at elaboration
    for (genvar g = 0; g < rsdpxy_pkg::TRIG_DEPTH; g++)
    begin : g_rom
        assign rom_w[g] = TW'(rsdpxy_pkg::quarter_sin(g, TRIG_FRAC_BITS));
    end

    // registered reads
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_data_reg <= rom_w[sin_addr];
            cos_data_reg <= rom_w[cos_addr];
        end
    end

    assign sin_data = sin_data_reg;
    assign cos_data = cos_data_reg;

endmodule

### sv/rsdpxy_project.sv
// ----------------------------------------------------------------------------
// rsdpxy_project
// Scales the range by cosine and sine, truncates toward zero, applies the
// cosine sign and holds the result beat in the output register.
// ----------------------------------------------------------------------------
module rsdpxy_project #(
    parameter int unsigned TRIG_FRAC_BITS = rsdpxy_pkg::TRIG_FRAC_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      s1_valid,
    input  rsdpxy_pkg::sample_meta_t  s1_meta,
    input  logic [TRIG_FRAC_BITS:0]   sin_data,
    input  logic [TRIG_FRAC_BITS:0]   cos_data,
    output logic                      out_valid,
    output logic [8:0]                sample_index,
    output logic [15:0]               range_value,
    output logic signed [16:0]        x_coord,
    output logic [15:0]               y_coord,
    output logic                      last_sample
);

    localparam int unsigned PRW = 16 + TRIG_FRAC_BITS + 1;

    // stage 2, aligned with the table read
    logic                     s2_valid_reg;
    rsdpxy_pkg::sample_meta_t s2_meta_reg;

    // output register
    logic               out_valid_reg;
    logic [8:0]         sample_index_reg;
    logic [15:0]        range_value_reg;
    logic signed [16:0] x_coord_reg;
    logic signed [16:0] x_coord_next;
    logic [15:0]        y_coord_reg;
    logic [15:0]        y_coord_next;
    logic               last_sample_reg;

    logic [PRW-1:0] x_prod;
    logic [PRW-1:0] y_prod;
    logic [16:0]    x_mag;

    // magnitude products, truncated by the shift
    assign x_prod       = PRW'(s2_meta_reg.range_value) * PRW'(cos_data);
    assign y_prod       = PRW'(s2_meta_reg.range_value) * PRW'(sin_data);
    assign x_mag        = x_prod[TRIG_FRAC_BITS +: 17];
    assign y_coord_next = y_prod[TRIG_FRAC_BITS +: 16];
    assign x_coord_next = s2_meta_reg.cos_neg ? $signed(17'd0 - x_mag) : $signed(x_mag);

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg  <= s1_valid;
            out_valid_reg <= s2_valid_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_meta_reg      <= s1_meta;
            sample_index_reg <= s2_meta_reg.sample_index;
            range_value_reg  <= s2_meta_reg.range_value;
            last_sample_reg  <= s2_meta_reg.last_sample;
            x_coord_reg      <= x_coord_next;
            y_coord_reg      <= y_coord_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign sample_index = sample_index_reg;
    assign range_value  = range_value_reg;
    assign x_coord      = x_coord_reg;
    assign y_coord      = y_coord_reg;
    assign last_sample  = last_sample_reg;

endmodule

### test/range_scan_xy_checker.sv
// ----------------------------------------------------------------------------
// range_scan_xy_checker
// Watches the byte, configuration and sample channels of the range scan
// deframer. It keeps its own copy of the registers and framing state, works
// out the sample beat each accepted byte should cause, and compares every
// accepted sample beat against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module range_scan_xy_checker #(
    parameter int unsigned MAX_SAMPLES    = rsdpxy_pkg::MAX_SAMPLES_DEF,
    parameter int unsigned TRIG_FRAC_BITS = rsdpxy_pkg::TRIG_FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_ready,
    input  logic [7:0]                         rx_byte,
    input  logic                               out_valid,
    input  logic                               out_ready,
    input  logic [8:0]                         sample_index,
    input  logic [15:0]                        range_value,
    input  logic signed [16:0]                 x_coord,
    input  logic [15:0]                        y_coord,
    input  logic                               last_sample,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [rsdpxy_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rsdpxy_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                                 fail_count,
    output int                                 pending_count
);

    timeunit 1ns;
    timeprecision 1ps;

    import rsdpxy_pkg::*;

    typedef struct packed {
        logic [8:0]  sample_index;
        logic [15:0] range_value;
        logic [16:0] x_coord;
        logic [15:0] y_coord;
        logic        last_sample;
    } xy_sample_t;

    // predicted sample beats, oldest first
    xy_sample_t  expected_samples[$];
    int          mismatches;

    // register copy
    logic        link_enabled;
    logic [9:0]  samples_cfg;
    logic [2:0]  step_cfg;
    logic [9:0]  offset_cfg;

    // framing copy
    int unsigned skipped;
    int unsigned frame_pos;
    logic [7:0]  held_low;

    // sin(a*pi/720) for 0 <= a <= 360 in Q1.frac, from a Q30 taylor series
    function automatic logic [63:0] arc_sine_fixed(input int unsigned quarter_deg);
        logic [63:0] theta;
        logic [63:0] theta_sq;
        logic [63:0] series_term;
        logic [63:0] series_sum;
        theta       = (64'(quarter_deg) * PI_Q30) / 64'(ANGLE_MAX);
        theta_sq    = (theta * theta) >> 30;
        series_term = theta;
        series_sum  = theta;
        for (int unsigned k = 1; k <= 12; k++)
        begin
            series_term = ((series_term * theta_sq) >> 30) / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1)
            begin
                series_sum = (series_sum >= series_term) ? (series_sum - series_term) : 64'd0;
            end
            else
            begin
                series_sum = series_sum + series_term;
            end
        end
        return (series_sum + (64'd1 << (29 - TRIG_FRAC_BITS))) >> (30 - TRIG_FRAC_BITS);
    endfunction

    // report one differing field
    task automatic note_field(input string field, input int want_v, input int got_v);
        if (want_v != got_v)
        begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, field, want_v, got_v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        int unsigned n_eff;
        int unsigned data_pos;
        int unsigned idx;
        int unsigned angle;
        logic [63:0] sin_q;
        logic [63:0] cos_q;
        logic [63:0] x_mag;
        logic [63:0] y_mag;
        logic        cos_negative;
        logic [15:0] range_word;
        xy_sample_t  want;
        if (!rst_n)
        begin
            expected_samples.delete();
            mismatches    = 0;
            link_enabled  = 1'b0;
            samples_cfg   = SAMPLE_COUNT_RST;
            step_cfg      = ANGLE_STEP_RST;
            offset_cfg    = ANGLE_OFFSET_RST;
            skipped       = 0;
            frame_pos     = 0;
            held_low      = 8'd0;
            fail_count    <= 0;
            pending_count <= 0;
        end
        else
        begin
            // sample beat taken by the receiver
            if (out_valid && out_ready)
            begin
                if (expected_samples.size() == 0)
                begin
                    mismatches++;
                    $display("%0t ns: sample beat with none expected, actual index %0d range %0d",
                             $time, sample_index, range_value);
                end
                else
                begin
                    want = expected_samples.pop_front();
                    note_field("sample_index", int'(want.sample_index), int'(sample_index));
                    note_field("range_value", int'(want.range_value), int'(range_value));
                    note_field("x_coord", int'($signed(want.x_coord)), int'(x_coord));
                    note_field("y_coord", int'(want.y_coord), int'(y_coord));
                    note_field("last_sample", int'(want.last_sample), int'(last_sample));
                end
            end

            // byte beat, dropped while the link is off; uses the registers as
            // they were before a write in the same cycle
            if (in_valid && in_ready && link_enabled)
            begin
                if (skipped < SKIP_BYTES)
                begin
                    skipped++;
                end
                else
                begin
                    n_eff = samples_cfg;
                    if (n_eff == 0)
                        n_eff = 1;
                    if (n_eff > MAX_SAMPLES)
                        n_eff = MAX_SAMPLES;
                    if (frame_pos >= HEAD_BYTES && frame_pos < HEAD_BYTES + 2 * n_eff)
                    begin
                        data_pos = frame_pos - HEAD_BYTES;
                        if (data_pos % 2 == 0)
                        begin
                            held_low = rx_byte;
                        end
                        else
                        begin
                            // high half completes a sample
                            idx        = data_pos / 2;
                            range_word = {rx_byte, held_low};
                            angle      = idx * step_cfg + offset_cfg;
                            if (angle > ANGLE_MAX)
                                angle = ANGLE_MAX;
                            if (angle <= ANGLE_HALF)
                            begin
                                sin_q        = arc_sine_fixed(angle);
                                cos_q        = arc_sine_fixed(ANGLE_HALF - angle);
                                cos_negative = 1'b0;
                            end
                            else
                            begin
                                sin_q        = arc_sine_fixed(ANGLE_MAX - angle);
                                cos_q        = arc_sine_fixed(angle - ANGLE_HALF);
                                cos_negative = 1'b1;
                            end
                            x_mag = (64'(range_word) * cos_q) >> TRIG_FRAC_BITS;
                            y_mag = (64'(range_word) * sin_q) >> TRIG_FRAC_BITS;
                            want.sample_index = idx[8:0];
                            want.range_value  = range_word;
                            want.x_coord      = cos_negative ? 17'(64'd0 - x_mag) : x_mag[16:0];
                            want.y_coord      = y_mag[15:0];
                            want.last_sample  = (idx == n_eff - 1);
                            expected_samples.push_back(want);
                        end
                    end
                    frame_pos++;
                    if (frame_pos >= HEAD_BYTES + 2 * n_eff + TAIL_BYTES)
                        frame_pos = 0;
                end
            end

            // register write beat
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_CONTINUOUS_ON:
                    begin
                        link_enabled = cfg_data[0];
                        if (cfg_data[0])
                        begin
                            skipped   = 0;
                            frame_pos = 0;
                        end
                    end
                    REG_SAMPLE_COUNT: samples_cfg = cfg_data;
                    REG_ANGLE_STEP:   step_cfg    = cfg_data[2:0];
                    REG_ANGLE_OFFSET: offset_cfg  = cfg_data;
                    default: ;
                endcase
            end

            fail_count    <= mismatches;
            pending_count <= expected_samples.size();
        end
    end

endmodule

### test/tb_range_scan_deframe_polar_to_xy.sv
// ----------------------------------------------------------------------------
// tb_range_scan_deframe_polar_to_xy
// Drives link bytes and register writes into the range scan deframer with
// random idling on both channels and one long receiver hold-off. A side
// checker predicts and compares every sample beat; this module only makes
// stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module tb_range_scan_deframe_polar_to_xy;

    timeunit 1ns;
    timeprecision 1ps;

    import rsdpxy_pkg::*;

    localparam int unsigned ITEM_TARGET = 1800;
    localparam int unsigned CYCLE_LIMIT = 3000000;
    localparam int unsigned DRAIN_TAIL  = 8;
    localparam int unsigned LONG_HOLD   = 400;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic [7:0]             rx_byte;
    logic                   out_valid;
    logic                   out_ready;
    logic [8:0]             sample_index;
    logic [15:0]            range_value;
    logic signed [16:0]     x_coord;
    logic [15:0]            y_coord;
    logic                   last_sample;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int                     check_failures;
    int                     pending_samples;
    int unsigned            cycle_count = 0;

    // shared between the stimulus and the receiver
    logic                   no_idle = 1'b0;
    int                     hold_requests = 0;

    range_scan_deframe_polar_to_xy dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .sample_index (sample_index),
        .range_value  (range_value),
        .x_coord      (x_coord),
        .y_coord      (y_coord),
        .last_sample  (last_sample),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    range_scan_xy_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .sample_index  (sample_index),
        .range_value   (range_value),
        .x_coord       (x_coord),
        .y_coord       (y_coord),
        .last_sample   (last_sample),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (check_failures),
        .pending_count (pending_samples)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t ns: timeout after %0d cycles", $time, cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // idle length: mostly short, a few long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 80)
            return $urandom_range(1, 3);
        else if (roll < 95)
            return $urandom_range(4, 20);
        else
            return $urandom_range(40, 120);
    endfunction

    // one byte beat, valid stays high after acceptance
    task automatic push_byte(input logic [7:0] value);
        int gap;
        gap = 0;
        if (!no_idle && $urandom_range(0, 99) < 30)
            gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= value;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic push_random(input int unsigned count);
        for (int unsigned i = 0; i < count; i++)
            push_byte(8'($urandom));
    endtask

    // one packet: header, little-endian ranges, trailer
    task automatic send_scan(input int unsigned samples, input bit extremes);
        logic [15:0] sample_range;
        push_random(HEAD_BYTES);
        for (int unsigned j = 0; j < samples; j++)
        begin
            if (extremes)
                sample_range = j[0] ? 16'hFFFF : 16'h0000;
            else
            begin
                case ($urandom_range(0, 9))
                    0:       sample_range = 16'h0000;
                    1:       sample_range = 16'hFFFF;
                    default: sample_range = 16'($urandom);
                endcase
            end
            push_byte(sample_range[7:0]);
            push_byte(sample_range[15:8]);
        end
        push_random(TAIL_BYTES);
    endtask

    // register write beat, valid stays high after acceptance
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic setup_scan(input logic [9:0] samples, input logic [2:0] step,
                              input logic [9:0] offset, input bit enable);
        write_reg(REG_SAMPLE_COUNT, samples);
        write_reg(REG_ANGLE_STEP, {7'($urandom), step});
        write_reg(REG_ANGLE_OFFSET, offset);
        if (enable)
            write_reg(REG_CONTINUOUS_ON, {9'($urandom), 1'b1});
        cfg_valid <= 1'b0;
    endtask

    // stop sending, wait for all samples and for the pipeline to empty
    task automatic drain();
        in_valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending_samples != 0)
            @(posedge clk);
        repeat (DRAIN_TAIL) @(posedge clk);
    endtask

    // receiver: random ready with gaps, plus long hold-offs on request
    initial
    begin : receiver
        int   run_left;
        int   idle_left;
        int   hold_left;
        int   holds_served;
        logic ready_next;
        run_left     = 0;
        idle_left    = 0;
        hold_left    = 0;
        holds_served = 0;
        out_ready    = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (holds_served != hold_requests)
            begin
                holds_served = hold_requests;
                hold_left    = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                ready_next = 1'b0;
            end
            else
            begin
                if (run_left == 0 && idle_left == 0)
                begin
                    run_left  = $urandom_range(1, 30);
                    idle_left = ($urandom_range(0, 99) < 35) ? pick_gap() : 0;
                end
                if (no_idle)
                    idle_left = 0;
                if (idle_left > 0)
                begin
                    idle_left--;
                    ready_next = 1'b0;
                end
                else
                begin
                    run_left--;
                    ready_next = 1'b1;
                end
            end
            out_ready <= ready_next;
        end
    end

    // stimulus and verdict
    initial
    begin : stimulus
        int unsigned items_sent;
        int unsigned phase_no;
        int unsigned n_eff;
        int unsigned packets;
        int unsigned sent;
        int unsigned tail;
        bit          link_on;
        bit          restart;
        bit          quiet;
        logic [9:0]  n_cfg;
        logic [2:0]  step_cfg;
        logic [9:0]  off_cfg;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        rx_byte   = 8'd0;
        cfg_valid = 1'b0;
        cfg_index = REG_CONTINUOUS_ON;
        cfg_data  = '0;
        items_sent = 0;
        phase_no   = 0;
        link_on    = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: link off drops bytes, then skip, header, range extremes,
        // zero step and an offset past the clamp angle
        push_byte(8'h00);
        push_byte(8'hFF);
        in_valid <= 1'b0;
        setup_scan(10'd2, 3'd0, 10'd1023, 1'b1);
        link_on = 1'b1;
        push_random(SKIP_BYTES);
        send_scan(2, 1'b1);
        drain();

        // random phases; the first is one packet at the largest size, the
        // second uses a zero sample count, the third holds off the receiver
        // while bytes keep coming
        while (items_sent < ITEM_TARGET)
        begin
            quiet = (phase_no == 2) || ($urandom_range(0, 99) < 20);
            no_idle <= quiet;
            if (phase_no > 2 && $urandom_range(0, 99) < 12)
            begin
                // link off: bytes are dropped
                write_reg(REG_CONTINUOUS_ON, {9'($urandom), 1'b0});
                cfg_valid <= 1'b0;
                link_on = 1'b0;
                push_random($urandom_range(3, 20));
            end
            else
            begin
                if (phase_no == 0)
                    n_cfg = 10'($urandom_range(512, 1023));
                else if (phase_no == 1)
                    n_cfg = 10'd0;
                else if (phase_no == 2)
                    n_cfg = 10'd8;
                else
                begin
                    case ($urandom_range(0, 19))
                        0:       n_cfg = 10'd0;
                        1:       n_cfg = 10'($urandom_range(41, 120));
                        2, 3, 4: n_cfg = 10'($urandom_range(9, 40));
                        default: n_cfg = 10'($urandom_range(1, 8));
                    endcase
                end
                case ($urandom_range(0, 9))
                    0:       step_cfg = 3'd0;
                    1:       step_cfg = 3'd7;
                    default: step_cfg = 3'($urandom_range(1, 6));
                endcase
                case ($urandom_range(0, 4))
                    0:       off_cfg = 10'd0;
                    1:       off_cfg = 10'd720;
                    2:       off_cfg = 10'($urandom_range(721, 1023));
                    3:       off_cfg = 10'($urandom_range(600, 720));
                    default: off_cfg = 10'($urandom_range(0, 720));
                endcase
                restart = !link_on || phase_no < 3 || ($urandom_range(0, 99) < 80);
                setup_scan(n_cfg, step_cfg, off_cfg, restart);
                link_on = 1'b1;
                n_eff = n_cfg;
                if (n_eff == 0)
                    n_eff = 1;
                if (n_eff > MAX_SAMPLES_DEF)
                    n_eff = MAX_SAMPLES_DEF;
                packets = (phase_no == 0) ? 1 : $urandom_range(1, 4);
                if (phase_no == 2)
                begin
                    packets = 3;
                    hold_requests <= hold_requests + 1;
                end
                sent = 0;
                if (restart)
                begin
                    push_random(SKIP_BYTES);
                    sent = SKIP_BYTES;
                end
                for (int unsigned p = 0; p < packets; p++)
                    send_scan(n_eff, 1'b0);
                sent += packets * (HEAD_BYTES + 2 * n_eff + TAIL_BYTES);
                // broken sequence: a partial packet left behind
                if ($urandom_range(0, 99) < 25)
                begin
                    tail = $urandom_range(1, HEAD_BYTES + 2 * n_eff + TAIL_BYTES - 1);
                    push_random(tail);
                    sent += tail;
                end
                items_sent += sent;
            end
            drain();
            phase_no++;
        end

        if (check_failures == 0 && pending_samples == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
